[hw/rtl/spectral_transition_scale_factor_macros.svh]
// Assertion macros for the spectral transition scale factor block
`ifndef SPECTRAL_TRANSITION_SCALE_FACTOR_MACROS_SVH
`define SPECTRAL_TRANSITION_SCALE_FACTOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stsf assertion failed");

// antecedent implies consequent in the next cycle
`define STSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stsf assertion failed");

`endif

[hw/rtl/stsf_pkg.sv]
// Package: constants, codes and types of the spectral transition scale factor block
`default_nettype none
package stsf_pkg;
  localparam int MaxTransitions = 128;
  localparam int IdxW = $clog2(MaxTransitions);
  localparam int CntW = $clog2(MaxTransitions + 1);
  localparam int EnW = 32;
  localparam int StrW = 24;
  localparam int WordW = EnW + StrW;
  localparam int DivW = 64;
  localparam logic [31:0] C1Q30 = 32'd2528468770;
  localparam logic [31:0] KQ32 = 32'd2447262796;

  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeEval   = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatNone  = 2'd2,
    StatZeroW = 2'd3
  } status_e;

  typedef enum logic {
    CfgFwhmMin = 1'b0,
    CfgFwhmMax = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/stsf_table.sv]
// Transition table: one-write, one-read synchronous memory of energy and strength
`default_nettype none
module stsf_table (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [stsf_pkg::IdxW-1:0]  waddr_i,
  input  logic [stsf_pkg::WordW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [stsf_pkg::IdxW-1:0]  raddr_i,
  output logic [stsf_pkg::WordW-1:0] rdata_o
);
  import stsf_pkg::*;

  logic [WordW-1:0] mem_q [MaxTransitions];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[hw/rtl/stsf_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module stsf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stsf_pkg::div_req_t req_i,
  output stsf_pkg::div_rsp_t rsp_o
);
  import stsf_pkg::*;

  localparam int StepW = $clog2(DivW);

  logic [DivW:0]      rem_q, rem_d;
  logic [DivW-1:0]    nq_q, nq_d;
  logic [DivW-1:0]    den_q, den_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivW:0]      shifted;

  always_comb begin
    rem_d   = rem_q;
    nq_d    = nq_q;
    den_d   = den_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[DivW-1:0], nq_q[DivW-1]};
    if (req_i.start && !busy_q) begin
      rem_d  = '0;
      nq_d   = req_i.num;
      den_d  = req_i.den;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        nq_d  = {nq_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        nq_d  = {nq_q[DivW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q;
endmodule
`default_nettype wire

[hw/rtl/spectral_transition_scale_factor.sv]
// Spectral transition scale factor: top level with sequencer, table and divider
//
// Clear, append and ignored modes finish straight from idle: the result strobes on valid_o in
// the cycle after start, and busy_o stays low. An evaluate walks the stored transitions
// one at a time through a single 64-bit bit-serial divider: each entry that is selected
// with a nonzero width takes a division (none once a zero width has been seen), and a
// final division forms the result where one is needed. busy_o is high for the whole
// walk; valid_o strobes once, in the cycle busy_o falls. Results hold until the next
// start: sample them when valid_o is high. Configuration writes take effect at once and
// belong between transactions.
`default_nettype none
module spectral_transition_scale_factor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] position_i,
  input  logic [23:0] strength_i,
  input  logic [31:0] intensity_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [31:0] scale_value_o,
  output logic [1:0]  status_o,
  output logic [7:0]  selected_count_o
);
  import stsf_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StRead = 7'b0000010,
    StMul  = 7'b0000100,
    StTest = 7'b0001000,
    StDiv  = 7'b0010000,
    StFin  = 7'b0100000,
    StFdiv = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   nxt_idx;
  logic [31:0]       fmin_q, fmax_q;
  logic [31:0]       pos_q, pos_d;
  logic [31:0]       int_q, int_d;
  logic [7:0]        sel_q, sel_d;
  logic              zero_q, zero_d;
  logic [63:0]       sum_q, sum_d;
  logic [32:0]       mag_q, mag_d;
  logic [StrW-1:0]   str_q, str_d;
  logic [33:0]       w_q, w_d;
  logic [55:0]       num_q, num_d;
  logic              valid_q, valid_d;
  logic [31:0]       scale_q, scale_d;
  logic [1:0]        status_q, status_d;
  logic [7:0]        cnt_q, cnt_d;

  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic [WordW-1:0]  mem_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic signed [32:0] diff;
  logic [64:0]        wprod;
  logic               in_range;
  logic [64:0]        sum_ext;
  logic [31:0]        imag;
  logic [63:0]        quo;

  stsf_table u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({position_i, strength_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmin_q <= '0;
      fmax_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFwhmMin: fmin_q <= cfg_wdata_i;
        CfgFwhmMax: fmax_q <= cfg_wdata_i;
        default:    fmin_q <= fmin_q;
      endcase
    end
  end

  assign nxt_idx  = idx_q + 1'b1;
  assign diff     = $signed({mem_rdata[WordW-1], mem_rdata[WordW-1:StrW]}) -
                    $signed({pos_q[31], pos_q});
  assign wprod    = 65'(mag_q) * 65'(C1Q30) + 65'(64'd1 << 29);
  assign in_range = (w_q >= {2'b00, fmin_q}) && (w_q <= {2'b00, fmax_q});
  assign sum_ext  = {1'b0, sum_q} + {1'b0, div_rsp.quo};
  assign imag     = int_q[31] ? 32'(-int_q) : int_q;
  assign quo      = div_rsp.quo;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    int_d    = int_q;
    sel_d    = sel_q;
    zero_d   = zero_q;
    sum_d    = sum_q;
    mag_d    = mag_q;
    str_d    = str_q;
    w_d      = w_q;
    num_d    = num_q;
    valid_d  = 1'b0;
    scale_d  = scale_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];
    div_req  = '0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          scale_d  = '0;
          status_d = StatOk;
          cnt_d    = '0;
          unique case (mode_e'(mode_i))
            ModeClear: begin
              count_d = '0;
              valid_d = 1'b1;
            end
            ModeAppend: begin
              valid_d = 1'b1;
              if (count_q < CntW'(MaxTransitions)) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                status_d = StatFull;
              end
            end
            ModeEval: begin
              pos_d  = position_i;
              int_d  = intensity_i;
              sel_d  = '0;
              zero_d = 1'b0;
              sum_d  = '0;
              idx_d  = '0;
              if (count_q == '0) begin
                status_d = StatNone;
                valid_d  = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = StRead;
              end
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      StRead: begin
        mag_d   = diff[32] ? 33'(-diff) : 33'(diff);
        str_d   = mem_rdata[StrW-1:0];
        state_d = StMul;
      end
      StMul: begin
        w_d     = wprod[63:30];
        num_d   = 56'(KQ32) * 56'(str_q);
        state_d = StTest;
      end
      StTest, StDiv: begin
        if (state_q == StTest && in_range) begin
          sel_d = (sel_q == 8'hFF) ? sel_q : sel_q + 1'b1;
          if (w_q == '0) begin
            zero_d = 1'b1;
          end
        end
        if (state_q == StTest && in_range && w_q != '0 && !zero_q) begin
          div_req.start = 1'b1;
          div_req.num   = {8'b0, num_q};
          div_req.den   = {30'b0, w_q};
          state_d       = StDiv;
        end else if (state_q == StTest || div_rsp.done) begin
          if (state_q == StDiv) begin
            sum_d = sum_ext[64] ? '1 : sum_ext[63:0];
          end
          if (nxt_idx < count_q) begin
            idx_d     = nxt_idx;
            mem_re    = 1'b1;
            mem_raddr = nxt_idx[IdxW-1:0];
            state_d   = StRead;
          end else begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        cnt_d = sel_q;
        if (sel_q == '0) begin
          scale_d  = '0;
          status_d = StatNone;
          valid_d  = 1'b1;
          state_d  = StIdle;
        end else if (zero_q) begin
          scale_d  = '0;
          status_d = StatZeroW;
          valid_d  = 1'b1;
          state_d  = StIdle;
        end else if (imag == '0 || sum_q == '0) begin
          status_d = StatOk;
          scale_d  = (imag == '0) ? 32'h0 : (int_q[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
          valid_d  = 1'b1;
          state_d  = StIdle;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {imag, 32'b0};
          div_req.den   = sum_q;
          state_d       = StFdiv;
        end
      end
      StFdiv: begin
        if (div_rsp.done) begin
          status_d = StatOk;
          if (int_q[31]) begin
            scale_d = (quo >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
          end else begin
            scale_d = (quo >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
          end
          valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    int_q    <= int_d;
    sel_q    <= sel_d;
    zero_q   <= zero_d;
    sum_q    <= sum_d;
    mag_q    <= mag_d;
    str_q    <= str_d;
    w_q      <= w_d;
    num_q    <= num_d;
    scale_q  <= scale_d;
    status_q <= status_d;
    cnt_q    <= cnt_d;
  end

  assign busy_o           = (state_q != StIdle);
  assign valid_o          = valid_q;
  assign scale_value_o    = scale_q;
  assign status_o         = status_q;
  assign selected_count_o = cnt_q;
endmodule
`default_nettype wire

[hw/rtl/stsf_checker.sv]
// Port-level checker for the spectral transition scale factor block, with its bind
`default_nettype none
`include "spectral_transition_scale_factor_macros.svh"
module stsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [31:0] scale_value_o,
  input logic [1:0]  status_o,
  input logic [7:0]  selected_count_o
);
  import stsf_pkg::*;

  `STSF_ASSERT_NXT(a_accept_answers, clk_i, rst_ni, start_i && !busy_o, busy_o || valid_o)
  `STSF_ASSERT_IMP(a_done_strobes, clk_i, rst_ni, $fell(busy_o), valid_o)
  `STSF_ASSERT_IMP(a_none_zero, clk_i, rst_ni, valid_o && status_o == StatNone, scale_value_o == 32'h0 && selected_count_o == 8'h0)
  `STSF_ASSERT_IMP(a_zerow_zero, clk_i, rst_ni, valid_o && status_o == StatZeroW, scale_value_o == 32'h0 && selected_count_o != 8'h0)
  `STSF_ASSERT_IMP(a_full_zero, clk_i, rst_ni, valid_o && status_o == StatFull, scale_value_o == 32'h0 && selected_count_o == 8'h0)
endmodule

bind spectral_transition_scale_factor stsf_checker u_stsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .valid_o          (valid_o),
  .scale_value_o    (scale_value_o),
  .status_o         (status_o),
  .selected_count_o (selected_count_o)
);
`default_nettype wire
